### hw/rtl/cse_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cse_pkg
// Shared types, constants and the saturation helper for the Chebyshev
// series evaluator.
// ---------------------------------------------------------------------------
package cse_pkg;

  localparam int Q_W            = 32;
  localparam int ONE_Q          = 65536;
  localparam int SUM_W          = 53;
  localparam int DEG_CFG_W      = 3;
  localparam int CFG_IDX_W      = 8;
  localparam int DIV_STEPS      = 32;
  localparam int MAX_DEGREE_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE     = CFG_IDX_W'(2);
  localparam int                   REG_COEF_BASE  = 3;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              ovf;
    logic              rerr;
    logic [Q_W-1:0]    rem;
    logic [Q_W-1:0]    dvd;
    logic [Q_W-1:0]    quo;
  } div_word_t;

  typedef struct packed {
    logic                    valid;
    logic                    rerr;
    logic                    sat;
    logic signed [Q_W-1:0]   t;
    logic signed [Q_W-1:0]   tprev;
    logic signed [Q_W-1:0]   tcur;
    logic signed [SUM_W-1:0] sum;
  } series_word_t;

  // Clips a wide signed value to Q16.16; the top bit of the result is the flag.
  function automatic logic [Q_W:0] clip_q(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    hi_lim = {{(SUM_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
    lo_lim = ~hi_lim;
    if (v > hi_lim) begin
      return {1'b1, hi_lim[Q_W-1:0]};
    end else if (v < lo_lim) begin
      return {1'b1, lo_lim[Q_W-1:0]};
    end
    return {1'b0, v[Q_W-1:0]};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/cse_div_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cse_div_cell
// One restoring division step: brings in one dividend bit and yields one
// quotient bit.
// ---------------------------------------------------------------------------
module cse_div_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic [cse_pkg::Q_W-1:0] den,
  input  cse_pkg::div_word_t     d_in,
  output cse_pkg::div_word_t     d_out
);
  import cse_pkg::*;

  div_word_t  d_r;
  div_word_t  d_nxt;
  logic [Q_W:0] r2;
  logic [Q_W:0] diff;
  logic         ge;

  always_comb begin
    r2    = {d_in.rem, d_in.dvd[Q_W-1]};
    diff  = r2 - {1'b0, den};
    ge    = (r2 >= {1'b0, den});
    d_nxt = d_in;
    d_nxt.rem = ge ? diff[Q_W-1:0] : r2[Q_W-1:0];
    d_nxt.dvd = {d_in.dvd[Q_W-2:0], 1'b0};
    d_nxt.quo = {d_in.quo[Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r.valid <= d_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r.neg  <= d_nxt.neg;
      d_r.ovf  <= d_nxt.ovf;
      d_r.rerr <= d_nxt.rerr;
      d_r.rem  <= d_nxt.rem;
      d_r.dvd  <= d_nxt.dvd;
      d_r.quo  <= d_nxt.quo;
    end
  end

  assign d_out = d_r;

endmodule
`default_nettype wire

### hw/rtl/cse_term_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cse_term_cell
// Adds the term of degree K to the running sum when the configured degree
// is at least K, and advances the Chebyshev recurrence by one degree.
// ---------------------------------------------------------------------------
module cse_term_cell #(
  parameter int K     = 1,
  parameter int DEG_W = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [DEG_W-1:0]               deg,
  input  logic signed [cse_pkg::Q_W-1:0] coef,
  input  cse_pkg::series_word_t          s_in,
  output cse_pkg::series_word_t          s_out
);
  import cse_pkg::*;

  series_word_t            s_r;
  series_word_t            s_nxt;
  logic signed [2*Q_W-1:0] prod_c;
  logic signed [2*Q_W-1:0] prod_t;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] tn_w;
  logic [Q_W:0]            tn_c;

  always_comb begin
    prod_c = coef * s_in.tcur;
    prod_t = s_in.t * s_in.tcur;
    term   = SUM_W'(prod_c >>> 16);
    tn_w   = SUM_W'(prod_t >>> 15) - SUM_W'(s_in.tprev);
    tn_c   = clip_q(tn_w);
    s_nxt  = s_in;
    if (int'(deg) >= K) begin
      s_nxt.sum = s_in.sum + term;
    end
    // The next polynomial is only built when a later cell still uses it.
    if (int'(deg) > K) begin
      s_nxt.tprev = s_in.tcur;
      s_nxt.tcur  = $signed(tn_c[Q_W-1:0]);
      s_nxt.sat   = s_in.sat | tn_c[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else if (en) begin
      s_r.valid <= s_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r.rerr  <= s_nxt.rerr;
      s_r.sat   <= s_nxt.sat;
      s_r.t     <= s_nxt.t;
      s_r.tprev <= s_nxt.tprev;
      s_r.tcur  <= s_nxt.tcur;
      s_r.sum   <= s_nxt.sum;
    end
  end

  assign s_out = s_r;

endmodule
`default_nettype wire

### hw/rtl/chebyshev_series_eval_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chebyshev_series_eval_top
// Maps a Q16.16 sample onto the Chebyshev interval and returns the
// saturated sum of coef_k * T_k(t) up to the configured degree.
// ---------------------------------------------------------------------------
// Throughput: one word per cycle; the 32-cell divider chain and the term
// cells are fully pipelined and all stall together when the output is held.
// Reset: synchronous, active low; clears all valid bits and loads the
// register defaults (range -1.0 to 1.0, degree 0, coef_0 = 1.0).
module chebyshev_series_eval_top #(
  parameter int MAX_DEGREE = cse_pkg::MAX_DEGREE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [cse_pkg::Q_W-1:0]     in_x_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [cse_pkg::Q_W-1:0]     out_series_value,
  output logic                               out_saturated,
  output logic                               out_range_error,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cse_pkg::Q_W-1:0]            cfg_wdata
);
  import cse_pkg::*;

  localparam int DEG_W = $clog2(MAX_DEGREE + 1);

  logic signed [Q_W-1:0]       range_low_r;
  logic signed [Q_W-1:0]       range_high_r;
  logic [DEG_CFG_W-1:0]        highest_degree_r;
  logic signed [Q_W-1:0]       coef_r [0:MAX_DEGREE];
  logic [DEG_W-1:0]            deg_eff;
  logic                        adv;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r      <= -Q_W'(ONE_Q);
      range_high_r     <= Q_W'(ONE_Q);
      highest_degree_r <= '0;
      for (int k = 0; k <= MAX_DEGREE; k++) begin
        coef_r[k] <= (k == 0) ? Q_W'(ONE_Q) : '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == REG_RANGE_LOW) begin
        range_low_r <= cfg_wdata;
      end
      if (cfg_index == REG_RANGE_HIGH) begin
        range_high_r <= cfg_wdata;
      end
      if (cfg_index == REG_DEGREE) begin
        highest_degree_r <= cfg_wdata[DEG_CFG_W-1:0];
      end
      for (int k = 0; k <= MAX_DEGREE; k++) begin
        if (cfg_index == CFG_IDX_W'(k + REG_COEF_BASE)) begin
          coef_r[k] <= cfg_wdata;
        end
      end
    end
  end

  always_comb begin
    if (int'(highest_degree_r) > MAX_DEGREE) begin
      deg_eff = DEG_W'(MAX_DEGREE);
    end else begin
      deg_eff = DEG_W'(highest_degree_r);
    end
  end

  // The whole pipeline moves whenever the output register can take a word.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Front stage: numerator magnitude, sign and divider seed.
  logic signed [Q_W+2:0] num;
  logic signed [Q_W:0]   den_w;
  logic [Q_W-1:0]        den;
  logic [Q_W+1:0]        mag;
  div_word_t             s0_nxt;
  div_word_t             div_chain [0:DIV_STEPS];

  assign den_w = (Q_W+1)'(range_high_r) - (Q_W+1)'(range_low_r);
  assign den   = den_w[Q_W-1:0];

  always_comb begin
    num = ((Q_W+3)'(in_x_value) <<< 1) - (Q_W+3)'(range_low_r) - (Q_W+3)'(range_high_r);
    mag = num[Q_W+2] ? (Q_W+2)'(-num) : (Q_W+2)'(num);
    s0_nxt.valid = in_valid;
    s0_nxt.neg   = num[Q_W+2];
    s0_nxt.rerr  = (range_high_r <= range_low_r);
    // The quotient exceeds 32 bits when the upper dividend part reaches den.
    s0_nxt.ovf   = ({{(Q_W-18){1'b0}}, mag[Q_W+1:16]} >= den);
    s0_nxt.rem   = {{(Q_W-18){1'b0}}, mag[Q_W+1:16]};
    s0_nxt.dvd   = {mag[15:0], 16'b0};
    s0_nxt.quo   = '0;
  end

  div_word_t s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
    end else if (adv) begin
      s0_r.valid <= s0_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r.neg  <= s0_nxt.neg;
      s0_r.ovf  <= s0_nxt.ovf;
      s0_r.rerr <= s0_nxt.rerr;
      s0_r.rem  <= s0_nxt.rem;
      s0_r.dvd  <= s0_nxt.dvd;
      s0_r.quo  <= s0_nxt.quo;
    end
  end

  assign div_chain[0] = s0_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    cse_div_cell u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .den   (den),
      .d_in  (div_chain[i]),
      .d_out (div_chain[i+1])
    );
  end

  // Sign, clip and seed of the recurrence.
  div_word_t             dq;
  logic signed [Q_W-1:0] t_val;
  logic                  t_sat;
  series_word_t          ser0_nxt;
  series_word_t          ser0_r;
  series_word_t          ser_chain [0:MAX_DEGREE];

  assign dq = div_chain[DIV_STEPS];

  always_comb begin
    t_sat = 1'b0;
    t_val = $signed(dq.quo);
    if (dq.ovf) begin
      t_sat = 1'b1;
      t_val = dq.neg ? $signed({1'b1, {(Q_W-1){1'b0}}}) : $signed({1'b0, {(Q_W-1){1'b1}}});
    end else if (!dq.neg) begin
      if (dq.quo[Q_W-1]) begin
        t_sat = 1'b1;
        t_val = $signed({1'b0, {(Q_W-1){1'b1}}});
      end
    end else begin
      if (dq.quo > {1'b1, {(Q_W-1){1'b0}}}) begin
        t_sat = 1'b1;
        t_val = $signed({1'b1, {(Q_W-1){1'b0}}});
      end else begin
        t_val = $signed(-dq.quo);
      end
    end
    ser0_nxt.valid = dq.valid;
    ser0_nxt.rerr  = dq.rerr;
    ser0_nxt.sat   = t_sat;
    ser0_nxt.t     = t_val;
    ser0_nxt.tprev = Q_W'(ONE_Q);
    ser0_nxt.tcur  = t_val;
    ser0_nxt.sum   = SUM_W'(coef_r[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser0_r.valid <= 1'b0;
    end else if (adv) begin
      ser0_r.valid <= ser0_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ser0_r.rerr  <= ser0_nxt.rerr;
      ser0_r.sat   <= ser0_nxt.sat;
      ser0_r.t     <= ser0_nxt.t;
      ser0_r.tprev <= ser0_nxt.tprev;
      ser0_r.tcur  <= ser0_nxt.tcur;
      ser0_r.sum   <= ser0_nxt.sum;
    end
  end

  assign ser_chain[0] = ser0_r;

  for (genvar k = 1; k <= MAX_DEGREE; k++) begin : g_term
    cse_term_cell #(
      .K     (k),
      .DEG_W (DEG_W)
    ) u_term (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .deg   (deg_eff),
      .coef  (coef_r[k]),
      .s_in  (ser_chain[k-1]),
      .s_out (ser_chain[k])
    );
  end

  // Output register.
  series_word_t          sf;
  logic [Q_W:0]          sum_c;
  logic                  out_valid_r;
  logic signed [Q_W-1:0] out_value_r;
  logic                  out_sat_r;
  logic                  out_rerr_r;

  assign sf    = ser_chain[MAX_DEGREE];
  assign sum_c = clip_q(sf.sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sf.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rerr_r  <= sf.rerr;
      out_value_r <= sf.rerr ? '0 : $signed(sum_c[Q_W-1:0]);
      out_sat_r   <= sf.rerr ? 1'b0 : (sf.sat | sum_c[Q_W]);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_series_value = out_value_r;
  assign out_saturated    = out_sat_r;
  assign out_range_error  = out_rerr_r;

  // An empty range always reports a zero value without saturation.
  a_rerr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_series_value == '0 && !out_saturated)
    else $error("range error word carries a nonzero value");

  // A held output word keeps the pipeline frozen.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // An accepted input word is in the front stage register in the next cycle.
  a_front: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s0_r.valid)
    else $error("accepted word lost in front stage");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

### verif/chebyshev_series_eval_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chebyshev_series_eval_checker
// Watches the sample, result and register channels of the Chebyshev series
// evaluator. It keeps its own copy of the registers, predicts one result for
// each accepted sample and compares every result word with the oldest one.
// ---------------------------------------------------------------------------
module chebyshev_series_eval_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [cse_pkg::Q_W-1:0] in_x_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [cse_pkg::Q_W-1:0] out_series_value,
  input  logic                          out_saturated,
  input  logic                          out_range_error,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [cse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cse_pkg::Q_W-1:0]       cfg_wdata,
  output int                            errors,
  output int                            pending
);
  import cse_pkg::*;

  localparam int DEG_LIMIT = MAX_DEGREE_DEF;
  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;

  typedef struct {
    logic signed [Q_W-1:0] value;
    logic                  sat;
    logic                  rerr;
  } series_result_t;

  logic signed [Q_W-1:0] lo_reg;
  logic signed [Q_W-1:0] hi_reg;
  logic [DEG_CFG_W-1:0]  deg_reg;
  logic signed [Q_W-1:0] coef_reg [0:DEG_LIMIT];

  series_result_t expected_results [$];

  function automatic longint clip_q16(input longint v, inout logic flag);
    if (v > Q_HI) begin
      flag = 1'b1;
      return Q_HI;
    end
    if (v < Q_LO) begin
      flag = 1'b1;
      return Q_LO;
    end
    return v;
  endfunction

  function automatic series_result_t eval_series(input logic signed [Q_W-1:0] x);
    series_result_t r;
    longint lo, hi, num, den, t, tprev, tcur, tnext, sum;
    int deg;
    logic sat;
    lo = lo_reg;
    hi = hi_reg;
    sat = 1'b0;
    r.value = '0;
    r.sat = 1'b0;
    r.rerr = 1'b0;
    if (hi <= lo) begin
      r.rerr = 1'b1;
      return r;
    end
    deg = (deg_reg > DEG_LIMIT) ? DEG_LIMIT : int'(deg_reg);
    num = 2 * longint'(x) - lo - hi;
    den = hi - lo;
    // Signed division truncates toward zero, as the hardware divider does.
    t = clip_q16((num * 65536) / den, sat);
    sum = coef_reg[0];
    tprev = 65536;
    tcur = t;
    for (int k = 1; k <= deg; k++) begin
      sum += (longint'(coef_reg[k]) * tcur) >>> 16;
      if (k == deg) break;
      tnext = ((t * tcur) >>> 15) - tprev;
      tnext = clip_q16(tnext, sat);
      tprev = tcur;
      tcur = tnext;
    end
    sum = clip_q16(sum, sat);
    r.value = sum[Q_W-1:0];
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    errors++;
  endtask

  initial errors = 0;
  assign pending = expected_results.size();

  always @(posedge clk) begin
    series_result_t want;
    if (!rst_n) begin
      lo_reg <= -32'sd65536;
      hi_reg <= 32'sd65536;
      deg_reg <= '0;
      for (int k = 0; k <= DEG_LIMIT; k++) coef_reg[k] <= (k == 0) ? 32'sd65536 : '0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) expected_results.push_back(eval_series(in_x_value));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_series_value !== want.value)
            report_mismatch($sformatf("series_value %0d, expected %0d",
                                      out_series_value, want.value));
          if (out_saturated !== want.sat)
            report_mismatch($sformatf("saturated %0b, expected %0b",
                                      out_saturated, want.sat));
          if (out_range_error !== want.rerr)
            report_mismatch($sformatf("range_error %0b, expected %0b",
                                      out_range_error, want.rerr));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_RANGE_LOW) lo_reg <= cfg_wdata;
        else if (cfg_index == REG_RANGE_HIGH) hi_reg <= cfg_wdata;
        else if (cfg_index == REG_DEGREE) deg_reg <= cfg_wdata[DEG_CFG_W-1:0];
        else if (cfg_index >= REG_COEF_BASE && cfg_index <= REG_COEF_BASE + DEG_LIMIT)
          coef_reg[cfg_index - REG_COEF_BASE] <= cfg_wdata;
      end
    end
  end

endmodule

### verif/tb_chebyshev_series_eval_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_chebyshev_series_eval_top
// Drives samples and register writes into the Chebyshev series evaluator
// with random gaps and output stalls: a directed set of range, degree and
// coefficient corners first, then random settings with random samples.
// ---------------------------------------------------------------------------
module tb_chebyshev_series_eval_top;
  import cse_pkg::*;

  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [Q_W-1:0] in_x_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [Q_W-1:0] out_series_value;
  logic out_saturated;
  logic out_range_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [Q_W-1:0] cfg_wdata = '0;
  int errors;
  int pending;
  int stall_left = 0;

  always #6 clk = ~clk;

  chebyshev_series_eval_top uut (.*);

  chebyshev_series_eval_checker checker_i (.*);

  // Output stalls: mostly short, now and then a long one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 3) begin
      stall_left <= $urandom_range(10, 40);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 19) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_sample(input logic [Q_W-1:0] x);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_value <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Registers must change only once every outstanding result has come back; write_reg itself does not wait.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_setting(input logic [Q_W-1:0] lo, input logic [Q_W-1:0] hi,
                              input logic [2:0] deg, input logic [Q_W-1:0] c0,
                              input logic [Q_W-1:0] c1, input logic [Q_W-1:0] c2,
                              input logic [Q_W-1:0] c3, input logic [Q_W-1:0] c4);
    wait_idle();
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
    write_reg(REG_DEGREE, {29'd0, deg});
    write_reg(CFG_IDX_W'(REG_COEF_BASE + 0), c0);
    write_reg(CFG_IDX_W'(REG_COEF_BASE + 1), c1);
    write_reg(CFG_IDX_W'(REG_COEF_BASE + 2), c2);
    write_reg(CFG_IDX_W'(REG_COEF_BASE + 3), c3);
    write_reg(CFG_IDX_W'(REG_COEF_BASE + 4), c4);
  endtask

  function automatic logic [Q_W-1:0] rand_coef(input bit full);
    if (full) return $urandom();
    return $signed($urandom_range(0, 262143)) - 131072;
  endfunction

  initial begin
    logic [Q_W-1:0] lo, hi;
    longint span;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: constant 1.0 over [-1, 1].
    send_sample(32'h0000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0001_0000);

    // Full degree, t and every T_k clip for samples far outside the range.
    load_setting(-32'sd65536, 32'sd65536, 3'd4, 32'sd32768, -32'sd65536,
                 32'sd131072, 32'sd16384, -32'sd98304);
    send_sample(32'hFFFF_0000);
    send_sample(32'h0001_0000);
    send_sample(32'h0000_8000);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);

    // Degree above the maximum is clamped; extreme coefficients saturate the sum.
    load_setting(32'h8000_0000, 32'h7FFF_FFFF, 3'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'hC000_0000);

    // Degree one, and writes to indexes past the list that must be ignored.
    load_setting(32'h0000_0000, 32'h0000_0001, 3'd1, 32'h8000_0000, 32'h7FFF_FFFF,
                 '0, '0, '0);
    write_reg(CFG_IDX_W'(REG_COEF_BASE + 5), 32'h1234_5678);
    write_reg(8'hFF, 32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0001);
    send_sample(32'h7FFF_FFFF);

    // Empty ranges: equal ends, then reversed ends.
    load_setting(32'sd65536, 32'sd65536, 3'd2, 32'sd65536, 32'sd65536, 32'sd65536, '0, '0);
    send_sample(32'h0001_0000);
    wait_idle();
    write_reg(REG_RANGE_HIGH, 32'h8000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);

    for (int ph = 0; ph < 8; ph++) begin
      if ($urandom_range(0, 3) == 0) begin
        lo = $urandom();
        hi = $urandom();
      end else begin
        lo = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        hi = lo + $urandom_range(1, 1 << 20);
      end
      load_setting(lo, hi, $urandom_range(0, 7), rand_coef(ph == 3), rand_coef(ph == 3),
                   rand_coef(ph == 5), rand_coef(0), rand_coef(ph == 6));
      span = longint'($signed(hi)) - longint'($signed(lo));
      for (int i = 0; i < 50; i++) begin
        if (span > 0 && $urandom_range(0, 9) < 8)
          send_sample(lo + Q_W'(longint'($urandom()) % (span + 1)));
        else
          send_sample($urandom());
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
